// File: design/clsr_pkg.sv
// Shared types, constants and helper functions for the combined LCG shuffle generator.
// No dependencies; every other design file imports this package.
package clsr_pkg;

  localparam int unsigned TABLE_SIZE = 32;
  localparam int unsigned SLOT_W = $clog2(TABLE_SIZE);
  localparam int unsigned WARM_STEPS = TABLE_SIZE + 8;
  localparam int unsigned WARM_W = $clog2(WARM_STEPS);

  localparam int unsigned GEN_W = 31;
  localparam int unsigned MUL_W = 16;
  localparam int unsigned PROD_W = GEN_W + MUL_W;
  localparam int unsigned FOLD_W = 8;

  localparam logic [GEN_W-1:0] MOD_A = 31'd2147483563;
  localparam logic [GEN_W-1:0] MOD_B = 31'd2147483399;
  localparam logic [MUL_W-1:0] MUL_A = 16'd40014;
  localparam logic [MUL_W-1:0] MUL_B = 16'd40692;
  localparam logic [FOLD_W-1:0] FOLD_A = FOLD_W'(32'h8000_0000 - 32'(MOD_A));
  localparam logic [FOLD_W-1:0] FOLD_B = FOLD_W'(32'h8000_0000 - 32'(MOD_B));
  localparam logic [GEN_W-1:0] OUT_TOP = GEN_W'(32'(MOD_A) - 32'd1);
  localparam logic [GEN_W-1:0] SECOND_RST = 31'd123456789;
  localparam logic [31:0] SLOT_DIV = 32'(1 + OUT_TOP / TABLE_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_WARM_M,
    S_WARM_W,
    S_DRAW,
    S_MUL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [GEN_W-1:0]  data;
  } tbl_wr_t;

  // Folds a product below 2^47 into the range of a modulus just under 2^31.
  function automatic logic [GEN_W-1:0] mod_fold(input logic [PROD_W-1:0] p,
                                                input logic [FOLD_W-1:0] fold,
                                                input logic [GEN_W-1:0] m);
    logic [31:0] sum;
    sum = 32'(p[GEN_W-1:0]) + 32'(p[PROD_W-1:GEN_W]) * 32'(fold);
    if (sum >= 32'(m)) begin
      sum = sum - 32'(m);
    end
    return sum[GEN_W-1:0];
  endfunction

  // Table slot picked by the previous output: the quotient by SLOT_DIV.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [GEN_W-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if (32'(v) >= 32'(k) * SLOT_DIV) begin
        idx = SLOT_W'(k);
      end
    end
    return idx;
  endfunction

endpackage

// File: design/clsr_gen.sv
// Two-stage step unit: multiplies both generators by their multipliers, then folds
// each product back below its modulus. Depends on clsr_pkg.
module clsr_gen (
  input  logic                       clk_i,
  input  logic [clsr_pkg::GEN_W-1:0] a_i,
  input  logic [clsr_pkg::GEN_W-1:0] b_i,
  output logic [clsr_pkg::GEN_W-1:0] na_o,
  output logic [clsr_pkg::GEN_W-1:0] nb_o
);
  import clsr_pkg::*;

  logic [PROD_W-1:0] pa_q, pb_q;
  logic [GEN_W-1:0]  na_q, nb_q;

  always_ff @(posedge clk_i) begin
    pa_q <= PROD_W'(a_i) * PROD_W'(MUL_A);
    pb_q <= PROD_W'(b_i) * PROD_W'(MUL_B);
    na_q <= mod_fold(pa_q, FOLD_A, MOD_A);
    nb_q <= mod_fold(pb_q, FOLD_B, MOD_B);
  end

  assign na_o = na_q;
  assign nb_o = nb_q;

endmodule

// File: design/clsr_table.sv
// Shuffle table: synchronous single-write, single-read memory with registered reads
// and per-entry valid bits so unwritten slots read as zero. Depends on clsr_pkg.
module clsr_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  clsr_pkg::tbl_rd_t          rd_i,
  input  clsr_pkg::tbl_wr_t          wr_i,
  output logic [clsr_pkg::GEN_W-1:0] rdata_o
);
  import clsr_pkg::*;

  logic [GEN_W-1:0]      mem [TABLE_SIZE];
  logic [GEN_W-1:0]      ram_q;
  logic [TABLE_SIZE-1:0] valid_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      ram_q <= mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rvalid_q <= valid_q[rd_i.addr];
      end
    end
  end

  assign rdata_o = rvalid_q ? ram_q : '0;

endmodule

// File: design/combined_lcg_shuffle_rng.sv
// Top level of the combined LCG generator with a Bays-Durham shuffle table.
// Depends on clsr_pkg, clsr_gen and clsr_table.
//
// Usage: each beat accepted on the input channel (in_valid_i/in_ready_o) yields one
// beat on the output channel (out_valid_o/out_ready_i) carrying value_o in
// 1..2147483562. With reseed_i high, both generators are first loaded from the seed
// register and the shuffle table is refilled before the number is drawn.
// The seed register is written through cfg_valid_i/cfg_seed_i, which is always ready.
// An ordinary draw passes through S_MUL and S_FIN before value_o is registered, and
// no new beat is taken until the block is back in S_IDLE; this is set by the table
// read addressed by the previous output and by the two-stage multiply-and-fold unit.
// A reseed draw first runs 40 warm-up steps through the same unit, each in S_WARM_M
// and S_WARM_W, and then the draw itself.
// Reset loads the generators with 1 and 123456789, the last output with 0, the seed
// with 1, and marks every table slot as cleared; no clearing pass is needed.
// If the receiver stalls, the finished result waits in the output register; the
// block still accepts the next beat and holds its final step until the register
// frees up.
module combined_lcg_shuffle_rng (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [clsr_pkg::GEN_W-1:0] cfg_seed_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       reseed_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [clsr_pkg::GEN_W-1:0] value_o
);
  import clsr_pkg::*;

  state_e            state_q, state_d;
  logic [GEN_W-1:0]  seed_q;
  logic [GEN_W-1:0]  first_q, first_d;
  logic [GEN_W-1:0]  second_q, second_d;
  logic [GEN_W-1:0]  last_q, last_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [WARM_W-1:0] warm_q, warm_d;
  logic [GEN_W-1:0]  value_q, value_d;
  logic              out_valid_q, out_valid_d;

  logic [GEN_W-1:0]  gen_a, gen_na, gen_nb;
  logic [GEN_W-1:0]  seed_eff;
  logic [GEN_W-1:0]  rdata;
  logic [GEN_W-1:0]  draw_v;
  logic [31:0]       lift;
  tbl_rd_t           rd;
  tbl_wr_t           wr;

  clsr_gen u_gen (
    .clk_i (clk_i),
    .a_i   (gen_a),
    .b_i   (second_q),
    .na_o  (gen_na),
    .nb_o  (gen_nb)
  );

  clsr_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (rd),
    .wr_i    (wr),
    .rdata_o (rdata)
  );

  assign seed_eff = (seed_q == '0) ? GEN_W'(1) : seed_q;
  assign lift     = 32'(rdata) + 32'(OUT_TOP) - 32'(gen_nb);
  assign draw_v   = (rdata > gen_nb) ? (rdata - gen_nb) : lift[GEN_W-1:0];

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    second_d    = second_q;
    last_d      = last_q;
    slot_d      = slot_q;
    warm_d      = warm_q;
    value_d     = value_q;
    out_valid_d = out_valid_q && !out_ready_i;
    gen_a       = first_q;
    rd          = '0;
    wr          = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (reseed_i) begin
            first_d  = seed_eff;
            second_d = seed_eff;
            warm_d   = WARM_W'(WARM_STEPS - 1);
            state_d  = S_SEED;
          end else begin
            rd.en   = 1'b1;
            rd.addr = slot_of(last_q);
            slot_d  = rd.addr;
            state_d = S_MUL;
          end
        end
      end
      S_SEED: begin
        state_d = S_WARM_M;
      end
      S_WARM_M: begin
        state_d = S_WARM_W;
      end
      S_WARM_W: begin
        gen_a   = gen_na;
        first_d = gen_na;
        if (32'(warm_q) < TABLE_SIZE) begin
          wr.en   = 1'b1;
          wr.addr = warm_q[SLOT_W-1:0];
          wr.data = gen_na;
        end
        if (warm_q == '0) begin
          last_d  = gen_na;
          state_d = S_DRAW;
        end else begin
          warm_d  = warm_q - WARM_W'(1);
          state_d = S_WARM_M;
        end
      end
      S_DRAW: begin
        rd.en   = 1'b1;
        rd.addr = slot_of(last_q);
        slot_d  = rd.addr;
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          wr.en       = 1'b1;
          wr.addr     = slot_q;
          wr.data     = gen_na;
          first_d     = gen_na;
          second_d    = gen_nb;
          last_d      = draw_v;
          value_d     = draw_v;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= GEN_W'(1);
      first_q     <= GEN_W'(1);
      second_q    <= SECOND_RST;
      last_q      <= '0;
      slot_q      <= '0;
      warm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      second_q    <= second_d;
      last_q      <= last_d;
      slot_q      <= slot_d;
      warm_q      <= warm_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        seed_q <= cfg_seed_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (value_o != '0) && (value_o <= OUT_TOP))
    else $error("output value out of range");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted beat did not start work");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && (state_d == S_IDLE) |=> out_valid_o)
    else $error("finished draw not presented on output");

  a_warm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WARM_M) || (state_q == S_WARM_W) |-> 32'(warm_q) < WARM_STEPS)
    else $error("warm-up counter out of bounds");

  a_table_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> 32'(wr.addr) < TABLE_SIZE)
    else $error("table write beyond last slot");

endmodule

// File: tb/tb_combined_lcg_shuffle_rng.sv
`timescale 1ns / 1ps
// Self-checking testbench for combined_lcg_shuffle_rng: directed beats, then random phases.
// Depends on clsr_pkg and the design top; it predicts every value and checks it in order.
module tb_combined_lcg_shuffle_rng;

  localparam int unsigned W = clsr_pkg::GEN_W;
  localparam int unsigned SLOTS = 32;
  localparam longint unsigned MOD_A = 64'd2147483563;
  localparam longint unsigned MOD_B = 64'd2147483399;
  localparam longint unsigned MUL_A = 64'd40014;
  localparam longint unsigned MUL_B = 64'd40692;
  localparam longint unsigned OUT_TOP = MOD_A - 64'd1;
  localparam longint unsigned SLOT_DIV = 64'd1 + OUT_TOP / SLOTS;
  localparam longint unsigned MASK31 = 64'h7FFF_FFFF;
  localparam logic [W-1:0] SEED_MAX = 31'd2147483646;
  localparam int unsigned N_DIRECTED = 23;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned PHASE_BEATS = 106;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic         load;
    logic [W-1:0] seed;
    logic         reseed;
    logic         known;
    logic [W-1:0] value;
  } directed_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [W-1:0] cfg_seed_i;
  logic         in_valid_i;
  logic         in_ready_o;
  logic         reseed_i;
  logic         out_valid_o;
  logic         out_ready_i;
  logic [W-1:0] value_o;

  longint unsigned seed_reg;
  longint unsigned gen_a;
  longint unsigned gen_b;
  longint unsigned prev_value;
  longint unsigned shuffle [SLOTS];

  logic [W-1:0] pending_values [$];
  int unsigned  errors;
  int unsigned  cycles;
  bit           calm;
  int unsigned  stall_left;
  directed_t    plan [N_DIRECTED];

  combined_lcg_shuffle_rng dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_seed_i  (cfg_seed_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .reseed_i    (reseed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [W-1:0] next_uniform(input bit do_reseed);
    longint unsigned s;
    longint unsigned v;
    longint unsigned slot;
    if (do_reseed) begin
      s = seed_reg & MASK31;
      if (s == 0) begin
        s = 1;
      end
      gen_a = s;
      gen_b = s;
      for (int k = SLOTS + 7; k >= 0; k--) begin
        gen_a = (MUL_A * gen_a) % MOD_A;
        if (k < SLOTS) begin
          shuffle[k] = gen_a;
        end
      end
      prev_value = shuffle[0];
    end
    gen_a = (MUL_A * gen_a) % MOD_A;
    gen_b = (MUL_B * gen_b) % MOD_B;
    slot = prev_value / SLOT_DIV;
    if (slot >= SLOTS) begin
      slot = SLOTS - 1;
    end
    v = shuffle[slot];
    if (v > gen_b) begin
      v = v - gen_b;
    end else begin
      v = v + OUT_TOP - gen_b;
    end
    shuffle[slot] = gen_a;
    prev_value = v & MASK31;
    return prev_value[W-1:0];
  endfunction

  // Holds one beat until it is taken, then records the value it must produce.
  task automatic issue_draw(input bit do_reseed, input bit known, input logic [W-1:0] typed);
    logic [W-1:0] predicted;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    reseed_i <= do_reseed;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    predicted = next_uniform(do_reseed);
    pending_values.push_back(known ? typed : predicted);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      reseed_i <= 1'($urandom);
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_seed_i <= v;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    seed_reg = longint'(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [W-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SEED_MAX;
      2: return W'(MOD_A);
      3: return W'(MOD_B);
      4: return 31'd1;
      default: return W'($urandom_range(0, 32'(SEED_MAX)));
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_values.size() == 0) begin
        $error("value: expected none, got %0d", value_o);
        errors++;
      end else begin
        if (value_o !== pending_values[0]) begin
          $error("value: expected %0d, got %0d", pending_values[0], value_o);
          errors++;
        end
        void'(pending_values.pop_front());
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_seed_i = '0;
    in_valid_i = 1'b0;
    reseed_i = 1'b0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    seed_reg = 1;
    gen_a = 1;
    gen_b = 123456789;
    prev_value = 0;
    foreach (shuffle[i]) shuffle[i] = 0;

    plan = '{
      '{1'b0, 31'd0,          1'b0, 1'b1, 31'd1407495835},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b1, 31'd0,          1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b1, 31'd2147483563, 1'b1, 1'b1, 31'd2140810074},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b1, 31'd2147483399, 1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b1, SEED_MAX,       1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b1, 31'd1,          1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0},
      '{1'b1, 31'h2AAA_AAAA,  1'b1, 1'b0, 31'd0},
      '{1'b1, 31'h5555_5555,  1'b1, 1'b0, 31'd0},
      '{1'b0, 31'd0,          1'b0, 1'b0, 31'd0}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].load) begin
        settle();
        write_seed(plan[i].seed);
      end
      issue_draw(plan[i].reseed, plan[i].known, plan[i].value);
      sender_gap();
    end

    for (int p = 0; p < N_PHASES; p++) begin
      // The pause before each seed write also lets every outstanding beat drain.
      settle();
      calm = (p == N_PHASES - 1) || ($urandom_range(0, 3) == 0);
      write_seed(pick_seed());
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n == 0) begin
          issue_draw($urandom_range(0, 3) != 0, 1'b0, '0);
        end else begin
          issue_draw($urandom_range(0, 11) == 0, 1'b0, '0);
        end
        sender_gap();
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
    if (pending_values.size() != 0) begin
      $error("value: %0d expected beats never arrived", pending_values.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: combined_lcg_shuffle_rng.f
design/clsr_pkg.sv
design/clsr_gen.sv
design/clsr_table.sv
design/combined_lcg_shuffle_rng.sv
tb/tb_combined_lcg_shuffle_rng.sv
